@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue unit: item formats,
// operation and status codes, register map and default sizes.
// -----------------------------------------------------------------------------
package spq_pkg;

   localparam int NUM_QUEUES_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int QIDX_W   = 3;
   localparam int SLOTS_W  = 5;
   localparam int STATUS_W = 2;

   localparam int CFG_CAP_W = 5;
   localparam int CFG_EN_W  = 4;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [CFG_CAP_W-1:0] CAP_RESET = 5'd16;

   // register index, taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_ENABLE   = 1'b1;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic                       operation;
      logic [QIDX_W-1:0]          queue_index;
      logic signed [KEY_W-1:0]    priority_key;
      logic [HANDLE_W-1:0]        element_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic [SLOTS_W-1:0]         slots_left;
      logic [HANDLE_W-1:0]        removed_handle;
   } rsp_type;

endpackage

@@ hw/rtl/sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Sequence: a rejected item (invalid queue, full, empty), or an enqueue into an empty queue,
// goes from acceptance straight to S_FINISH; an enqueue into a non-empty queue scans in S_ENQ,
// moving smaller entries up, then writes the item there or in S_PLACE; a dequeue reads the head
// in S_DEQ_HEAD and shifts the rest down in S_DEQ_SHIFT. S_FINISH hands on the result when free.
// Throughput: one item at a time; the next item is accepted once the current one is done.
// The rate is set by the entry memory: one entry is read and one moved per cycle.
// Reset: counts cleared, capacity 16, all queues disabled; the entry memory is not cleared.
// -----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Several bounded priority queues kept as sorted arrays (descending signed key)
// in one synchronous entry memory, with an APB-style register port.
// -----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int NUM_QUEUES  = spq_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  spq_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output spq_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [spq_pkg::PADDR_W-1:0]   paddr,
   input  logic [spq_pkg::PDATA_W-1:0]   pwdata,
   output logic [spq_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import spq_pkg::*;

   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int QSEL_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CAP_W     = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;
   localparam int ENTRY_W   = KEY_W + HANDLE_W;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_ENQ       = 6'b000010,
      S_PLACE     = 6'b000100,
      S_DEQ_HEAD  = 6'b001000,
      S_DEQ_SHIFT = 6'b010000,
      S_FINISH    = 6'b100000
   } state_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [QSEL_W-1:0] q,
                                                 input logic [IDX_W-1:0] idx);
      addr_of = ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx));
   endfunction

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [QSEL_W-1:0]         q_ff, q_in;
   logic signed [KEY_W-1:0]   key_ff, key_in;
   logic [HANDLE_W-1:0]       handle_ff, handle_in;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;
   logic [CFG_CAP_W-1:0]      cap_ff, cap_in;
   logic [CFG_EN_W-1:0]       mask_ff, mask_in;
   logic [CNT_W-1:0]          counts_ff [NUM_QUEUES];

   logic                      counts_we;
   logic [CNT_W-1:0]          counts_wd;

   logic [ENTRY_W-1:0]        mem [MEM_DEPTH];
   logic [ENTRY_W-1:0]        rd_data_ff;
   logic                      mem_we, mem_re;
   logic [ADDR_W-1:0]         mem_wa, mem_ra;
   logic [ENTRY_W-1:0]        mem_wd;

   logic [QSEL_W-1:0]         qs;
   logic                      q_ok;
   logic [CNT_W-1:0]          n_cur;
   logic [CAP_W-1:0]          n_ext, cap_ext, depth_c, cap_eff;
   logic signed [KEY_W-1:0]   rd_key;
   logic                      cfg_wr;

   assign qs      = QSEL_W'(req_data.queue_index);
   assign q_ok    = (int'(req_data.queue_index) < NUM_QUEUES)
                 && (int'(req_data.queue_index) < CFG_EN_W)
                 && mask_ff[req_data.queue_index[1:0]];
   assign n_cur   = counts_ff[qs];
   assign n_ext   = CAP_W'(n_cur);
   assign cap_ext = CAP_W'(cap_ff);
   assign depth_c = CAP_W'(QUEUE_DEPTH);
   assign cap_eff = (cap_ext > depth_c) ? depth_c : cap_ext;
   assign rd_key  = rd_data_ff[ENTRY_W-1:HANDLE_W];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign cap_in  = (cfg_wr && paddr[2] == REG_CAPACITY) ? pwdata[CFG_CAP_W-1:0] : cap_ff;
   assign mask_in = (cfg_wr && paddr[2] == REG_ENABLE) ? pwdata[CFG_EN_W-1:0] : mask_ff;
   assign prdata  = (paddr[2] == REG_ENABLE) ? PDATA_W'(mask_ff) : PDATA_W'(cap_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      key_in       = key_ff;
      handle_in    = handle_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      counts_we    = 1'b0;
      counts_wd    = n_cur;
      mem_we       = 1'b0;
      mem_wa       = addr_of(q_ff, pos_ff[IDX_W-1:0]);
      mem_wd       = {key_ff, handle_ff};
      mem_re       = 1'b0;
      mem_ra       = addr_of(q_ff, pos_ff[IDX_W-1:0]);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_in      = qs;
               key_in    = req_data.priority_key;
               handle_in = req_data.element_handle;
               res_in    = '{status: ST_OK, slots_left: '0, removed_handle: '0};
               state_in  = S_FINISH;
               if (!q_ok) begin
                  res_in.status = ST_INVALID;
               end else if (req_data.operation == OP_ENQUEUE) begin
                  if (n_ext >= cap_eff) begin
                     res_in.status = ST_FULL;
                  end else begin
                     res_in.slots_left = SLOTS_W'(cap_eff - n_ext - CAP_W'(1));
                     counts_we = 1'b1;
                     counts_wd = n_cur + CNT_W'(1);
                     if (n_cur == '0) begin
                        mem_we = 1'b1;
                        mem_wa = addr_of(qs, '0);
                        mem_wd = {req_data.priority_key, req_data.element_handle};
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = addr_of(qs, IDX_W'(n_cur - CNT_W'(1)));
                        pos_in   = n_cur;
                        state_in = S_ENQ;
                     end
                  end
               end else begin
                  if (n_cur == '0) begin
                     res_in.status = ST_EMPTY;
                  end else begin
                     counts_we = 1'b1;
                     counts_wd = n_cur - CNT_W'(1);
                     mem_re    = 1'b1;
                     mem_ra    = addr_of(qs, '0);
                     cnt_in    = n_cur;
                     state_in  = S_DEQ_HEAD;
                  end
               end
            end
         end
         S_ENQ: begin
            mem_we = 1'b1;
            if (key_ff > rd_key) begin
               // move the smaller entry up one slot; keep scanning, or go to S_PLACE at the head
               mem_wd = rd_data_ff;
               pos_in = pos_ff - CNT_W'(1);
               if (pos_ff == CNT_W'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  mem_re = 1'b1;
                  mem_ra = addr_of(q_ff, IDX_W'(pos_ff - CNT_W'(2)));
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PLACE: begin
            mem_we   = 1'b1;
            state_in = S_FINISH;
         end
         S_DEQ_HEAD: begin
            res_in.removed_handle = rd_data_ff[HANDLE_W-1:0];
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_FINISH;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = addr_of(q_ff, IDX_W'(1));
               pos_in   = CNT_W'(1);
               state_in = S_DEQ_SHIFT;
            end
         end
         S_DEQ_SHIFT: begin
            mem_we = 1'b1;
            mem_wa = addr_of(q_ff, IDX_W'(pos_ff - CNT_W'(1)));
            mem_wd = rd_data_ff;
            if (pos_ff + CNT_W'(1) < cnt_ff) begin
               mem_re = 1'b1;
               mem_ra = addr_of(q_ff, IDX_W'(pos_ff + CNT_W'(1)));
               pos_in = pos_ff + CNT_W'(1);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         mask_ff      <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         mask_ff      <= mask_in;
         if (counts_we) begin
            counts_ff[qs] <= counts_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      q_ff        <= q_in;
      key_ff      <= key_in;
      handle_ff   <= handle_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_wa != mem_ra))
      else $error("entry read and written in the same cycle");

   a_scan_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENQ) |-> (pos_ff != '0))
      else $error("insert scan below the head");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FINISH))
      else $error("result dropped while output busy");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish");

endmodule
